FILE: design/rmcd_pkg.sv
// Shared widths, constants and the data record passed along the root cell chain.
package rmcd_pkg;

  localparam int unsigned ChanW    = 8;
  localparam int unsigned SqW      = 2 * ChanW;       // squared channel difference
  localparam int unsigned WeightW  = 10;              // 512+mean and 767-mean
  localparam int unsigned TermW    = 18;              // each weighted term
  localparam int unsigned SumW     = 20;              // weighted sum
  localparam int unsigned FracBits = 4;
  localparam int unsigned RadW     = SumW + 2 * FracBits;  // radicand, sum times 256
  localparam int unsigned RootW    = RadW / 2;             // 14 result bits
  localparam int unsigned RemW     = RootW + 2;
  localparam int unsigned NumCells = RootW;

  localparam logic [WeightW-1:0] RedBase   = WeightW'(512);
  localparam logic [WeightW-1:0] BlueBase  = WeightW'(767);
  localparam int unsigned        GreenShft = 2;        // weight of four

  typedef struct packed {
    logic              valid;
    logic [RemW-1:0]   rem;
    logic [RootW-1:0]  root;
    logic [RadW-1:0]   rad;
  } rmcd_cell_t;

endpackage

FILE: design/redmean_colour_distance.sv
// Top level: redmean colour distance, weighting pipeline followed by a chain of root cells.
//
//   channel   direction  handshake                 payload
//   pair      in         pair_valid / pair_stall   first_*, second_* (8 bits each)
//   dist      out        dist_valid / dist_stall   distance_q4 (14 bits, 4 fraction bits)
//
// One request is taken every cycle unless a waiting result is stalled.
// The weighted sum is formed in registered stages (differences, squares and
// weights, weighted terms, add) and one root cell per result bit finishes the
// square root; the last cell's registers are the output register.
// Reset clears only the valid bits of every stage; payloads are left as they are.
// A stall on dist while a result is waiting holds the whole pipeline and raises
// pair_stall in the same cycle; bubbles are carried through, not squeezed out.
module redmean_colour_distance import rmcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  output logic             pair_stall,
  input  logic [ChanW-1:0] first_red,
  input  logic [ChanW-1:0] first_green,
  input  logic [ChanW-1:0] first_blue,
  input  logic [ChanW-1:0] second_red,
  input  logic [ChanW-1:0] second_green,
  input  logic [ChanW-1:0] second_blue,
  output logic             dist_valid,
  input  logic             dist_stall,
  output logic [RootW-1:0] distance_q4
);

  logic       advance;
  rmcd_cell_t link [NumCells+1];

  // advance whenever the output register is empty or is being taken
  assign advance    = !dist_valid || !dist_stall;
  assign pair_stall = !advance;

  rmcd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .in_valid     (pair_valid),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .seed         (link[0])
  );

  // one cell per result bit, most significant first
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rmcd_root_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (advance),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign dist_valid  = link[NumCells].valid;
  assign distance_q4 = link[NumCells].root;

endmodule

FILE: design/rmcd_front.sv
// Weighted squared-difference pipeline: forms the redmean sum and seeds the root chain.
module rmcd_front import rmcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [ChanW-1:0] first_red,
  input  logic [ChanW-1:0] first_green,
  input  logic [ChanW-1:0] first_blue,
  input  logic [ChanW-1:0] second_red,
  input  logic [ChanW-1:0] second_green,
  input  logic [ChanW-1:0] second_blue,
  output rmcd_cell_t       seed
);

  logic [3:0]         valid;
  // stage one
  logic [ChanW-1:0]   mean, dr, dg, db;
  // stage two
  logic [SqW-1:0]     dr2, dg2, db2;
  logic [WeightW-1:0] wr, wb;
  // stage three
  logic [TermW-1:0]   red_term, green_term, blue_term;
  // stage four
  logic [SumW-1:0]    sum;

  logic [ChanW:0]             red_sum;
  logic [WeightW+SqW-1:0]     red_prod, blue_prod;

  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  assign red_sum   = {1'b0, first_red} + {1'b0, second_red};
  assign red_prod  = {{SqW{1'b0}}, wr} * {{WeightW{1'b0}}, dr2};
  assign blue_prod = {{SqW{1'b0}}, wb} * {{WeightW{1'b0}}, db2};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean       <= red_sum[ChanW:1];
      dr         <= abs_diff(first_red, second_red);
      dg         <= abs_diff(first_green, second_green);
      db         <= abs_diff(first_blue, second_blue);

      dr2        <= {{ChanW{1'b0}}, dr} * {{ChanW{1'b0}}, dr};
      dg2        <= {{ChanW{1'b0}}, dg} * {{ChanW{1'b0}}, dg};
      db2        <= {{ChanW{1'b0}}, db} * {{ChanW{1'b0}}, db};
      wr         <= RedBase + {{(WeightW-ChanW){1'b0}}, mean};
      wb         <= BlueBase - {{(WeightW-ChanW){1'b0}}, mean};

      red_term   <= red_prod[8 +: TermW];
      blue_term  <= blue_prod[8 +: TermW];
      green_term <= {{(TermW-SqW-GreenShft){1'b0}}, dg2, {GreenShft{1'b0}}};

      sum        <= {2'b00, red_term} + {2'b00, green_term} + {2'b00, blue_term};
    end
  end

  assign seed.valid = valid[3];
  assign seed.rem   = '0;
  assign seed.root  = '0;
  assign seed.rad   = {sum, {(2 * FracBits){1'b0}}};

endmodule

FILE: design/rmcd_root_cell.sv
// One cell of the square-root chain: settles one result bit and passes the rest on.
module rmcd_root_cell import rmcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  rmcd_cell_t din,
  output rmcd_cell_t dout
);

  logic [RemW+1:0] rem_shift;
  logic [RemW+1:0] trial;
  logic            take;
  logic [RemW+1:0] rem_left;

  // bring down the next two radicand bits and try root*4+1
  assign rem_shift = {din.rem, din.rad[RadW-1 -: 2]};
  assign trial     = {2'b00, din.root, 2'b01};
  assign take      = rem_shift >= trial;
  assign rem_left  = take ? rem_shift - trial : rem_shift;

  // only the valid bit is reset; the payload just follows it
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.rem  <= rem_left[RemW-1:0];
      dout.root <= {din.root[RootW-2:0], take};
      dout.rad  <= {din.rad[RadW-3:0], 2'b00};
    end
  end

endmodule
